>>> rtl/dbas_pkg.sv
// Shared types, widths and register codes for the dual boxcar average scaler.
// Used by the channel interfaces, the lanes and the top level.
// Has no dependencies.
package dbas_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SPAN_W   = 12;
  localparam int PROD_W   = SAMPLE_W + SPAN_W;
  localparam int SCALED_W = 23;
  localparam int FAULT_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [SAMPLE_W-1:0] DEPTH_LOW_RST  = 10'd202;
  localparam logic [SAMPLE_W-1:0] DEPTH_HIGH_RST = 10'd219;
  localparam logic [SAMPLE_W-1:0] FLOW_LOW_RST   = 10'd210;
  localparam logic [SAMPLE_W-1:0] FLOW_HIGH_RST  = 10'd975;
  localparam logic [SPAN_W-1:0]   SPAN_RST       = 12'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_LOW   = 3'd0,
    CFG_DEPTH_HIGH  = 3'd1,
    CFG_FLOW_LOW    = 3'd2,
    CFG_FLOW_HIGH   = 3'd3,
    CFG_SCALED_SPAN = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_TOTAL,
    LN_AVG,
    LN_MUL,
    LN_DIV,
    LN_DONE
  } lane_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SPAN_W-1:0]   span;
  } lane_cfg_t;

  typedef struct packed {
    logic                       done;
    logic                       fault;
    logic [SAMPLE_W-1:0]        average;
    logic signed [SCALED_W-1:0] scaled;
  } lane_res_t;

endpackage

>>> rtl/dbas_if.sv
// Valid/ready channel interfaces: sample pairs in, results out, register writes.
// Depends on dbas_pkg for field widths.
interface dbas_in_if;
  import dbas_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] depth_sample;
  logic [SAMPLE_W-1:0] flow_sample;
  modport source(output valid, depth_sample, flow_sample, input ready);
  modport sink(input valid, depth_sample, flow_sample, output ready);
endinterface

interface dbas_out_if;
  import dbas_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [SAMPLE_W-1:0]        depth_average;
  logic [SAMPLE_W-1:0]        flow_average;
  logic signed [SCALED_W-1:0] depth_scaled;
  logic signed [SCALED_W-1:0] flow_scaled;
  logic [FAULT_W-1:0]         span_fault;
  modport source(output valid, depth_average, flow_average, depth_scaled, flow_scaled,
                 span_fault, input ready);
  modport sink(input valid, depth_average, flow_average, depth_scaled, flow_scaled,
               span_fault, output ready);
endinterface

interface dbas_cfg_if;
  import dbas_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/dbas_serial_div.sv
// Restoring unsigned divider producing one quotient bit per cycle.
// Self-contained; the divisor must be non-zero.
module dbas_serial_div #(
  parameter int NW = 22,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_q;
  logic [NW-1:0] quo;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // The dividend shifts out of the top of quo while quotient bits enter at the bottom.
  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};
  assign quot  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

>>> rtl/dbas_serial_mul.sv
// Shift-and-add unsigned multiplier consuming one multiplier bit per cycle.
// Self-contained.
module dbas_serial_mul #(
  parameter int AW = 10,
  parameter int BW = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  localparam int PW = AW + BW;
  localparam int CW = $clog2(AW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [AW-1:0] a_sh;
  logic [PW-1:0] b_sh;
  logic [PW-1:0] acc;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(AW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= a;
      b_sh <= PW'(b);
    end else if (busy) begin
      if (a_sh[0]) begin
        acc <= acc + b_sh;
      end
      a_sh <= a_sh >> 1;
      b_sh <= b_sh << 1;
    end
  end

endmodule

>>> rtl/dbas_lane.sv
// One averaging lane: sample ring with running total, serial divide for the
// average, then serial multiply and divide for the linear rescale.
// Depends on dbas_pkg, dbas_serial_div and dbas_serial_mul.
module dbas_lane #(
  parameter int WINDOW = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dbas_pkg::SAMPLE_W-1:0] sample,
  input  dbas_pkg::lane_cfg_t           cfg,
  input  logic                          take,
  output dbas_pkg::lane_res_t           res
);
  import dbas_pkg::*;

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TW = $clog2(WINDOW * 1023 + 1);

  lane_state_t state, state_next;

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]   ring_vld;
  logic [SW-1:0]       slot;
  logic [TW-1:0]       total;
  logic [TW-1:0]       total_next;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_vld;
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0] old;
  logic [SAMPLE_W-1:0] average;
  logic signed [SCALED_W-1:0] scaled;
  logic                fault;
  logic                neg;

  logic                load;
  logic                div_start;
  logic [PROD_W-1:0]   div_num;
  logic [SAMPLE_W-1:0] div_den;
  logic                div_done;
  logic [PROD_W-1:0]   div_quot;
  logic                mul_start;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;

  logic [SAMPLE_W-1:0] avg_q;
  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   diff_abs;
  logic                den_neg;
  logic [SAMPLE_W-1:0] den_mag;
  logic                span_eq;
  logic [SCALED_W-1:0] q_ext;

  assign load = start && (state == LN_IDLE);

  // A slot never written since reset counts as zero.
  assign old        = rd_vld ? rd_data : '0;
  assign total_next = total - TW'(old) + TW'(smp);

  assign avg_q    = div_quot[SAMPLE_W-1:0];
  assign diff     = {1'b0, avg_q} - {1'b0, cfg.lo};
  assign diff_abs = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
  assign den_neg  = cfg.hi < cfg.lo;
  assign den_mag  = den_neg ? (cfg.lo - cfg.hi) : (cfg.hi - cfg.lo);
  assign span_eq  = cfg.hi == cfg.lo;
  assign q_ext    = {1'b0, div_quot};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = PROD_W'(total_next);
    div_den    = SAMPLE_W'(WINDOW);
    mul_start  = 1'b0;
    unique case (state)
      LN_IDLE: begin
        if (load) begin
          state_next = LN_TOTAL;
        end
      end
      LN_TOTAL: begin
        div_start  = 1'b1;
        state_next = LN_AVG;
      end
      LN_AVG: begin
        if (div_done) begin
          if (span_eq) begin
            state_next = LN_DONE;
          end else begin
            mul_start  = 1'b1;
            state_next = LN_MUL;
          end
        end
      end
      LN_MUL: begin
        div_num = mul_prod;
        div_den = den_mag;
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = LN_DIV;
        end
      end
      LN_DIV: begin
        if (div_done) begin
          state_next = LN_DONE;
        end
      end
      LN_DONE: begin
        if (take) begin
          state_next = LN_IDLE;
        end
      end
      default: state_next = LN_IDLE;
    endcase
  end

  // Ring memory: the old entry is read as the new sample overwrites it.
  always_ff @(posedge clk) begin
    if (load) begin
      rd_data   <= mem[slot];
      mem[slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      slot     <= '0;
      total    <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (load) begin
        rd_vld         <= ring_vld[slot];
        ring_vld[slot] <= 1'b1;
        slot           <= (slot == SW'(WINDOW - 1)) ? '0 : slot + 1'b1;
      end
      if (state == LN_TOTAL) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      smp <= sample;
    end
    if (state == LN_AVG && div_done) begin
      average <= avg_q;
      fault   <= span_eq;
      neg     <= diff[SAMPLE_W] ^ den_neg;
      if (span_eq) begin
        scaled <= '0;
      end
    end
    if (state == LN_DIV && div_done) begin
      scaled <= neg ? $signed(SCALED_W'(0) - q_ext) : $signed(q_ext);
    end
  end

  dbas_serial_div #(
    .NW(PROD_W),
    .DW(SAMPLE_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  dbas_serial_mul #(
    .AW(SAMPLE_W),
    .BW(SPAN_W)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (diff_abs[SAMPLE_W-1:0]),
    .b    (cfg.span),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign res.done    = state == LN_DONE;
  assign res.fault   = fault;
  assign res.average = average;
  assign res.scaled  = scaled;

endmodule

>>> rtl/dual_boxcar_average_scaler_unit.sv
// Each input beat carries a depth and a flow sample; each enters its own circular window
// (DEPTH_WINDOW and FLOW_WINDOW entries, zero after reset) and one result beat follows with
// the floor average of each window and its linear rescale (avg-low)*span/(high-low), truncated
// toward zero and unclamped; a channel whose high equals low gives 0 and sets its fault bit.
// The two lanes run side by side, each through a bit-serial divider and multiplier: a lane
// takes an item through two 22-step divisions and one 10-step multiply, or through the first
// division alone when its span is faulted. A new beat is accepted once the previous result
// has moved into the output register. Register writes are accepted only while no item is in
// flight, and a pending write holds off new beats.
// Depends on dbas_pkg, dbas_if and dbas_lane.
module dual_boxcar_average_scaler_unit #(
  parameter int DEPTH_WINDOW = 50,
  parameter int FLOW_WINDOW  = 25
) (
  input  logic        clk,
  input  logic        rst,
  dbas_in_if.sink     samples,
  dbas_out_if.source  results,
  dbas_cfg_if.sink    cfg
);
  import dbas_pkg::*;

  logic [SAMPLE_W-1:0] depth_low;
  logic [SAMPLE_W-1:0] depth_high;
  logic [SAMPLE_W-1:0] flow_low;
  logic [SAMPLE_W-1:0] flow_high;
  logic [SPAN_W-1:0]   scaled_span;

  lane_cfg_t d_cfg, f_cfg;
  lane_res_t d_res, f_res;

  logic busy;
  logic out_vld;
  logic accept;
  logic xfer;
  logic [SAMPLE_W-1:0]        depth_average;
  logic [SAMPLE_W-1:0]        flow_average;
  logic signed [SCALED_W-1:0] depth_scaled;
  logic signed [SCALED_W-1:0] flow_scaled;
  logic [FAULT_W-1:0]         span_fault;

  // The lanes read the registers throughout an item, so writes wait until it has finished.
  assign cfg.ready     = !busy;
  assign samples.ready = !busy && !cfg.valid;
  assign accept        = samples.valid && !busy && !cfg.valid;
  assign xfer          = busy && d_res.done && f_res.done && (!out_vld || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_low   <= DEPTH_LOW_RST;
      depth_high  <= DEPTH_HIGH_RST;
      flow_low    <= FLOW_LOW_RST;
      flow_high   <= FLOW_HIGH_RST;
      scaled_span <= SPAN_RST;
    end else if (cfg.valid && !busy) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_DEPTH_LOW:   depth_low   <= cfg.data[SAMPLE_W-1:0];
        CFG_DEPTH_HIGH:  depth_high  <= cfg.data[SAMPLE_W-1:0];
        CFG_FLOW_LOW:    flow_low    <= cfg.data[SAMPLE_W-1:0];
        CFG_FLOW_HIGH:   flow_high   <= cfg.data[SAMPLE_W-1:0];
        CFG_SCALED_SPAN: scaled_span <= cfg.data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign d_cfg = '{lo: depth_low, hi: depth_high, span: scaled_span};
  assign f_cfg = '{lo: flow_low, hi: flow_high, span: scaled_span};

  dbas_lane #(.WINDOW(DEPTH_WINDOW)) u_depth (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .sample(samples.depth_sample),
    .cfg   (d_cfg),
    .take  (xfer),
    .res   (d_res)
  );

  dbas_lane #(.WINDOW(FLOW_WINDOW)) u_flow (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .sample(samples.flow_sample),
    .cfg   (f_cfg),
    .take  (xfer),
    .res   (f_res)
  );

  // Busy covers one item from acceptance until its result reaches the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (xfer) begin
        busy <= 1'b0;
      end
      if (xfer) begin
        out_vld <= 1'b1;
      end else if (results.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      depth_average <= d_res.average;
      flow_average  <= f_res.average;
      depth_scaled  <= d_res.scaled;
      flow_scaled   <= f_res.scaled;
      span_fault    <= {f_res.fault, d_res.fault};
    end
  end

  assign results.valid         = out_vld;
  assign results.depth_average = depth_average;
  assign results.flow_average  = flow_average;
  assign results.depth_scaled  = depth_scaled;
  assign results.flow_scaled   = flow_scaled;
  assign results.span_fault    = span_fault;

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> busy)
    else $error("accepted beat did not mark the block busy");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> results.valid)
    else $error("item finished without a result in the output register");

  a_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !d_res.done && !f_res.done)
    else $error("lane holds a result while no item is in flight");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.span_fault[0] |-> results.depth_scaled == '0)
    else $error("depth span fault with non-zero scaled value");

endmodule
